>>> rtl/mbet_pkg.sv
// Shared types, constants and helpers for the Mandelbrot escape-time pixel core.
package mbet_pkg;

	localparam int unsigned FRAC_BITS = 28;
	localparam int unsigned CNT_W     = 10;
	localparam int unsigned CNT_MAX   = 1023;
	localparam int unsigned COORD_W   = 9;

	// |z|^2 escape bound 4.0 in Q8.56
	localparam logic [63:0] ESCAPE_Q56 = 64'h0400_0000_0000_0000;

	// Configuration register indexes
	localparam logic [1:0] CFG_X_ORIGIN = 2'd0;
	localparam logic [1:0] CFG_Y_ORIGIN = 2'd1;
	localparam logic [1:0] CFG_STEP     = 2'd2;
	localparam logic [1:0] CFG_MAX_ITER = 2'd3;

	localparam logic signed [31:0] X_ORIGIN_RST = 32'shE000_0000;
	localparam logic signed [31:0] Y_ORIGIN_RST = 32'sh2000_0000;
	localparam logic [30:0]        STEP_RST     = 31'd2684355;
	localparam logic [CNT_W-1:0]   MAX_ITER_RST = 10'd1023;

	typedef struct packed {
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
	} mbet_pixel_t;

	typedef struct packed {
		logic [CNT_W-1:0] iterations;
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
	} mbet_result_t;

	typedef struct packed {
		logic signed [31:0] x_origin;
		logic signed [31:0] y_origin;
		logic [30:0]        step;
		logic [CNT_W-1:0]   max_iterations;
	} mbet_cfg_t;

	typedef struct packed {
		logic               start;
		logic               out_free;
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
	} mbet_cmd_t;

	typedef struct packed {
		logic             idle;
		logic             done;
		logic [CNT_W-1:0] count;
	} mbet_stat_t;

	// Clamp a 42-bit signed sum to the signed 32-bit Q4.28 range
	function automatic logic signed [31:0] sat_q(input logic signed [41:0] v);
		logic signed [31:0] r;
		if (!v[41] && (|v[40:31])) begin
			r = 32'sh7FFF_FFFF;
		end else if (v[41] && !(&v[40:31])) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/mbet_mul.sv
// Shared signed 32x32 multiplier with registered product.
module mbet_mul import mbet_pkg::*; (
	input  logic               clk,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic signed [63:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

>>> rtl/mbet_iter.sv
// Sequencer and datapath for one pixel's escape-time iteration.
module mbet_iter import mbet_pkg::*; #(
	parameter int unsigned ITER_LIMIT = 1023
) (
	input  logic       clk,
	input  logic       arst_n,
	input  mbet_cfg_t  cfg,
	input  mbet_cmd_t  cmd,
	output mbet_stat_t stat
);

	localparam int unsigned      CAP_INT = (ITER_LIMIT < CNT_MAX) ? ITER_LIMIT : CNT_MAX;
	localparam logic [CNT_W-1:0] CAP     = CNT_W'(CAP_INT);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_CRE  = 4'd1;
	localparam logic [3:0] ST_CIM  = 4'd2;
	localparam logic [3:0] ST_CSET = 4'd3;
	localparam logic [3:0] ST_XX   = 4'd4;
	localparam logic [3:0] ST_YY   = 4'd5;
	localparam logic [3:0] ST_XY   = 4'd6;
	localparam logic [3:0] ST_UPD  = 4'd7;
	localparam logic [3:0] ST_DONE = 4'd8;

	logic [3:0]         state_q;
	logic [COORD_W-1:0] col_q, row_q;
	logic [CNT_W-1:0]   lim_q, cnt_q, cnt_nxt;
	logic signed [31:0] c_re_q, c_im_q, x_q, y_q;
	logic signed [63:0] xx_q, diff_q;
	logic               esc_q;

	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod;
	logic [63:0]        mag;
	logic signed [41:0] re_sum, im_sum, xn_sum, yn_sum;
	logic signed [33:0] diff_sh, xy_sh;

	mbet_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod)
	);

	// Select the operands of the shared multiplier by sequencer step
	always_comb begin
		case (state_q)
			ST_CRE: begin
				mul_a = $signed({{(32-COORD_W){1'b0}}, col_q});
				mul_b = $signed({1'b0, cfg.step});
			end
			ST_CIM: begin
				mul_a = $signed({{(32-COORD_W){1'b0}}, row_q});
				mul_b = $signed({1'b0, cfg.step});
			end
			ST_YY: begin
				mul_a = y_q;
				mul_b = y_q;
			end
			ST_XY: begin
				mul_a = x_q;
				mul_b = y_q;
			end
			default: begin
				mul_a = x_q;
				mul_b = x_q;
			end
		endcase
	end

	assign re_sum  = {{10{cfg.x_origin[31]}}, cfg.x_origin} + $signed({2'b00, prod[39:0]});
	assign im_sum  = {{10{cfg.y_origin[31]}}, cfg.y_origin} - $signed({2'b00, prod[39:0]});
	assign mag     = {1'b0, xx_q[62:0]} + {1'b0, prod[62:0]};
	assign diff_sh = 34'(diff_q >>> FRAC_BITS);
	assign xy_sh   = 34'(prod >>> (FRAC_BITS - 1));
	assign xn_sum  = {{8{diff_sh[33]}}, diff_sh} + {{10{c_re_q[31]}}, c_re_q};
	assign yn_sum  = {{8{xy_sh[33]}}, xy_sh} + {{10{c_im_q[31]}}, c_im_q};
	assign cnt_nxt = cnt_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (cmd.start) state_q <= ST_CRE;
				ST_CRE:  state_q <= ST_CIM;
				ST_CIM:  state_q <= ST_CSET;
				ST_CSET: state_q <= (lim_q == '0) ? ST_DONE : ST_XX;
				ST_XX:   state_q <= ST_YY;
				ST_YY:   state_q <= ST_XY;
				ST_XY:   state_q <= ST_UPD;
				ST_UPD:  state_q <= (esc_q || cnt_nxt == lim_q) ? ST_DONE : ST_XX;
				ST_DONE: if (cmd.out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				col_q <= cmd.column;
				row_q <= cmd.row;
				lim_q <= (cfg.max_iterations > CAP) ? CAP : cfg.max_iterations;
			end
			ST_CIM: c_re_q <= sat_q(re_sum);
			ST_CSET: begin
				c_im_q <= sat_q(im_sum);
				x_q    <= '0;
				y_q    <= '0;
				cnt_q  <= '0;
			end
			ST_YY: xx_q <= prod;
			ST_XY: begin
				esc_q  <= (mag >= ESCAPE_Q56);
				diff_q <= xx_q - prod;
			end
			ST_UPD: begin
				if (!esc_q) begin
					cnt_q <= cnt_nxt;
					x_q   <= sat_q(xn_sum);
					y_q   <= sat_q(yn_sum);
				end
			end
			default: ;
		endcase
	end

	assign stat.idle  = (state_q == ST_IDLE);
	assign stat.done  = (state_q == ST_DONE) && cmd.out_free;
	assign stat.count = cnt_q;

endmodule

>>> rtl/mandelbrot_escape_time_pixel_core.sv
// Top level of the Mandelbrot escape-time pixel core.
// Takes one pixel (column, row) per transaction, maps it to the point
// c = (x_origin + column*step, y_origin - row*step) in saturated signed Q4.28,
// iterates z = z^2 + c from zero and returns the number of iterations taken
// while |z|^2 < 4, capped at the smaller of max_iterations and ITER_LIMIT,
// together with a color: red = green = low byte of the count, blue = that
// byte times 32. One pixel is in flight at a time. The sequencer first forms c
// (column*step, then row*step, then c itself with z and the count cleared);
// each pass then uses the one shared 32x32 multiplier to form x*x, y*y and
// x*y in turn, then updates z and the count (an escaping point takes one extra
// pass to see the escape), and a final state moves the result into the output
// register. The result sits in that output register, so the next pixel is taken
// while the previous result still waits. Configuration writes are always taken
// (cfg_ready is high) and must only be issued while the core is idle.
module mandelbrot_escape_time_pixel_core import mbet_pkg::*; #(
	parameter int unsigned ITER_LIMIT = 1023
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  mbet_pixel_t  in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output mbet_result_t out_data,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	mbet_cfg_t    cfg_q;
	mbet_cmd_t    cmd;
	mbet_stat_t   stat;
	logic         out_valid_q;
	mbet_result_t out_data_q;

	// Configuration registers: accept every write
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_origin       <= X_ORIGIN_RST;
			cfg_q.y_origin       <= Y_ORIGIN_RST;
			cfg_q.step           <= STEP_RST;
			cfg_q.max_iterations <= MAX_ITER_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_X_ORIGIN: cfg_q.x_origin       <= $signed(cfg_data);
				CFG_Y_ORIGIN: cfg_q.y_origin       <= $signed(cfg_data);
				CFG_STEP:     cfg_q.step           <= cfg_data[30:0];
				CFG_MAX_ITER: cfg_q.max_iterations <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Take a new pixel whenever the sequencer is idle
	assign in_ready     = stat.idle;
	assign cmd.start    = in_valid && in_ready;
	assign cmd.column   = in_data.column;
	assign cmd.row      = in_data.row;
	// Let the sequencer hand off only when the output register is free
	assign cmd.out_free = !out_valid_q || out_ready;

	mbet_iter #(
		.ITER_LIMIT (ITER_LIMIT)
	) u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.cmd    (cmd),
		.stat   (stat)
	);

	// Output register: load on hand-off, drop once the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done) begin
			out_data_q.iterations <= stat.count;
			out_data_q.red        <= stat.count[7:0];
			out_data_q.green      <= stat.count[7:0];
			out_data_q.blue       <= {stat.count[2:0], 5'b00000};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

>>> rtl/mbet_checker.sv
// Port-level assertions for the Mandelbrot escape-time pixel core, with bind.
module mbet_checker import mbet_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         in_valid,
	input logic         in_ready,
	input logic         out_valid,
	input logic         out_ready,
	input mbet_result_t out_data
);

	// A taken pixel keeps the core busy for at least the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after a transaction");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_red_green: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.red == out_data.iterations[7:0]
			&& out_data.green == out_data.iterations[7:0])
		else $error("red or green does not match the count");

	a_blue: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.blue == {out_data.iterations[2:0], 5'b00000})
		else $error("blue does not match the count");

endmodule

bind mandelbrot_escape_time_pixel_core mbet_checker u_mbet_checker (.*);

>>> sim/tb_top.sv
// Self-checking testbench for the Mandelbrot escape-time pixel core.
module tb_top;
	import mbet_pkg::*;

	// Parameter override for the core, and the matching cap in the predictor
	localparam int unsigned ITER_CAP     = 1023;
	localparam int unsigned BLUE_SCALE   = 32;
	// Random pixel transactions after the directed part
	localparam int unsigned RANDOM_ITEMS = 560;
	// Receiver hold-off used once to back the core up into its input
	localparam int unsigned LONG_HOLD    = 600;
	// Wait at the end, longer than the slowest pixel takes
	localparam int unsigned DRAIN_CYCLES = 4200;
	// Hang bound on the whole run, in clock cycles
	localparam int unsigned LIMIT_CYCLES = 2500000;
	// 1.0 in Q4.28
	localparam int          Q_ONE        = 268435456;

	// Predicts the escape count and color of each pixel and matches results in order
	class pixel_scoreboard;
		logic signed [31:0] x_origin;
		logic signed [31:0] y_origin;
		logic [30:0]        step;
		logic [CNT_W-1:0]   max_iter;
		mbet_result_t       expected_q[$];
		int unsigned        errors;

		function new();
			x_origin = X_ORIGIN_RST;
			y_origin = Y_ORIGIN_RST;
			step     = STEP_RST;
			max_iter = MAX_ITER_RST;
			errors   = 0;
		endfunction

		function void write_reg(logic [1:0] index, logic [31:0] data);
			case (index)
				CFG_X_ORIGIN: x_origin = data;
				CFG_Y_ORIGIN: y_origin = data;
				CFG_STEP:     step     = data[30:0];
				CFG_MAX_ITER: max_iter = data[CNT_W-1:0];
				default: ;
			endcase
		endfunction

		function longint clamp_q(longint v);
			longint hi, lo;
			hi = longint'(2147483647);
			lo = -hi - 1;
			if (v > hi) return hi;
			if (v < lo) return lo;
			return v;
		endfunction

		function int unsigned escape_count(mbet_pixel_t pix);
			longint c_re, c_im, zr, zi, diff, prod;
			longint unsigned zr2, zi2;
			int unsigned n, lim;
			bit escaped;
			c_re = clamp_q(longint'(x_origin) + longint'(pix.column) * longint'(step));
			c_im = clamp_q(longint'(y_origin) - longint'(pix.row) * longint'(step));
			lim = max_iter;
			if (lim > ITER_CAP) lim = ITER_CAP;
			zr = 0;
			zi = 0;
			n = 0;
			escaped = 1'b0;
			while (n < lim && !escaped) begin
				zr2 = zr * zr;
				zi2 = zi * zi;
				if (zr2 + zi2 >= ESCAPE_Q56) begin
					escaped = 1'b1;
				end else begin
					n++;
					// floor shifts; the xy shift is one less to form 2xy
					diff = longint'(zr2) - longint'(zi2);
					prod = zr * zi;
					zr = clamp_q((diff >>> FRAC_BITS) + c_re);
					zi = clamp_q((prod >>> (FRAC_BITS - 1)) + c_im);
				end
			end
			return n;
		endfunction

		function void note_pixel(mbet_pixel_t pix);
			int unsigned n;
			mbet_result_t r;
			n = escape_count(pix);
			r.iterations = CNT_W'(n);
			r.red        = 8'(n);
			r.green      = 8'(n);
			r.blue       = 8'(n * BLUE_SCALE);
			expected_q.push_back(r);
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function void flag(string msg);
			errors++;
			$display("%0t: %s", $time, msg);
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want)
				flag($sformatf("%s mismatch: expected %0d, actual %0d", field, want, got));
		endfunction

		function void check_result(mbet_result_t got);
			mbet_result_t want;
			if (expected_q.size() == 0) begin
				flag($sformatf("result with nothing expected: expected none, actual iterations %0d",
					got.iterations));
				return;
			end
			want = expected_q.pop_front();
			compare("iterations", 32'(want.iterations), 32'(got.iterations));
			compare("red", 32'(want.red), 32'(got.red));
			compare("green", 32'(want.green), 32'(got.green));
			compare("blue", 32'(want.blue), 32'(got.blue));
		endfunction
	endclass

	// Drive every input to a known value from time zero
	logic         clk       = 1'b0;
	logic         arst_n    = 1'b0;
	logic         in_valid  = 1'b0;
	logic         in_ready;
	mbet_pixel_t  in_data   = '0;
	logic         out_valid;
	logic         out_ready = 1'b0;
	mbet_result_t out_data;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [1:0]   cfg_index = CFG_X_ORIGIN;
	logic [31:0]  cfg_data  = '0;

	pixel_scoreboard sb = new();
	int unsigned     cycles        = 0;
	bit              src_steady    = 1'b0;
	bit              long_hold_req = 1'b0;

	mandelbrot_escape_time_pixel_core #(
		.ITER_LIMIT(ITER_CAP)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #1 clk = ~clk;

	// Gap length for either side: mostly none or short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// Abort on a hang; the bound is several times the slowest legal run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Check every result transaction; sample at the rising edge before the core updates
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready)
			sb.check_result(out_data);
	end

	// Result side: random stalls, calm stretches with ready held high,
	// and one long hold-off on request so the core fills and stalls its input
	initial begin
		int unsigned hold, calm;
		hold = 0;
		calm = 0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold = LONG_HOLD;
			end
			if (hold > 0) begin
				out_ready <= 1'b0;
				hold--;
			end else begin
				out_ready <= 1'b1;
				if (calm > 0)
					calm--;
				else if ($urandom_range(0, 63) == 0)
					calm = $urandom_range(30, 300);
				else
					hold = pick_gap();
			end
		end
	end

	// Offer one pixel, hold it until taken, note it, then idle for a random gap.
	// Valid stays high into the next call when the gap is zero.
	task automatic send_pixel(input int unsigned column, input int unsigned row);
		mbet_pixel_t pix;
		int unsigned gap;
		pix.column = column[COORD_W-1:0];
		pix.row    = row[COORD_W-1:0];
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= pix;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
		sb.note_pixel(pix);
		gap = src_steady ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// One register write transaction; mirror it in the predictor when taken
	task automatic load_reg(input logic [1:0] index, input logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		while (cfg_ready !== 1'b1) @(posedge clk);
		sb.write_reg(index, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_window(input logic [31:0] xo, input logic [31:0] yo,
			input logic [31:0] st, input logic [31:0] lim);
		load_reg(CFG_X_ORIGIN, xo);
		load_reg(CFG_Y_ORIGIN, yo);
		load_reg(CFG_STEP, st);
		load_reg(CFG_MAX_ITER, lim);
	endtask

	// Drop valid and wait until every pixel has come back; only then touch registers.
	// Every pixel yields a result, so an empty queue means the core is idle.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int unsigned sent, phase, n, lim, k;
		logic [31:0] xo, yo, st;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset window and limit: the far corners escape at once, and the last point lies
		// outside the main cardioid, above it
		send_pixel(0, 0);
		send_pixel(511, 511);
		send_pixel(511, 0);
		send_pixel(0, 511);
		send_pixel(170, 85);
		settle();

		// Zero limit: no iterations, count zero
		load_reg(CFG_MAX_ITER, 0);
		send_pixel(0, 0);
		send_pixel(511, 511);
		settle();

		// Limit of one on a bounded point and the smallest nonzero step
		load_window(0, 0, 1, 1);
		send_pixel(0, 0);
		send_pixel(511, 511);
		settle();

		// Coordinate overflow: c saturates high on the real axis, low on the imaginary
		load_window(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 3);
		send_pixel(511, 511);
		send_pixel(0, 0);
		send_pixel(1, 0);
		send_pixel(0, 1);
		settle();

		// Most negative and most positive origins with zero step
		load_window(32'h8000_0000, 32'h7FFF_FFFF, 0, 2);
		send_pixel(0, 0);
		send_pixel(511, 511);
		settle();

		// Real axis from -2: c = -2 lands exactly on |z|^2 = 4, c = -0.75 and
		// c near zero never escape and report the full limit
		load_window(32'hE000_0000, 0, 1310720, ITER_CAP);
		send_pixel(0, 0);
		send_pixel(256, 0);
		send_pixel(410, 0);
		send_pixel(120, 20);
		settle();

		// Random windows around the set with varied limits; every sixth phase zooms in
		// at the full limit, every sixth is pure noise in the registers.
		// The first phase keeps valid up while the receiver holds off for a long stretch.
		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			src_steady = ($urandom_range(0, 3) == 0);
			xo = 32'(-2 * Q_ONE - Q_ONE / 4 + int'($urandom_range(0, 5 * Q_ONE / 2)));
			yo = 32'(-Q_ONE + int'($urandom_range(0, 5 * Q_ONE / 2)));
			st = $urandom_range(1, 1 << 20);
			lim = $urandom_range(1, 160);
			n = 40;
			if (phase == 0) begin
				lim = $urandom_range(1, 12);
				n = 30;
				src_steady = 1'b1;
			end else if (phase % 6 == 3) begin
				st = $urandom_range(1, 1 << 16);
				lim = ITER_CAP;
				n = 8;
			end else if (phase % 6 == 5) begin
				xo = $urandom;
				yo = $urandom;
				st = $urandom;
				lim = $urandom_range(0, 63);
			end
			load_window(xo, yo, st, lim);
			if (phase == 0) long_hold_req = 1'b1;
			for (k = 0; k < n; k++)
				send_pixel($urandom_range(0, 511), $urandom_range(0, 511));
			sent += n;
			phase++;
			settle();
		end

		// Catch any stray result after the last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
